>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> rtl/lshs_pkg.sv
// ----------------------------------------------------------------------------
// Homing sequencer package
// Codes, result record and packed register field helpers.
// ----------------------------------------------------------------------------
package lshs_pkg;

   localparam int RES_SLOTS = 6;
   localparam logic [19:0] TICK_MAX = 20'hFFFFF;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_START   = 2'd1,
      OP_STOP    = 2'd2,
      OP_DISABLE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_STATUS = 3'd0,
      KIND_RATE   = 3'd1,
      KIND_TARGET = 3'd2,
      KIND_SETPOS = 3'd3,
      KIND_HALT   = 3'd4,
      KIND_EVENT  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_HOMING = 2'd1,
      MODE_FAULT  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_SEEK_FAST = 2'd0,
      PH_BACKOFF   = 2'd1,
      PH_SEEK_SLOW = 2'd2,
      PH_RELEASE   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_STARTED   = 3'd1,
      EV_ALL_HOMED = 3'd2,
      EV_TIMEOUT   = 3'd3,
      EV_STUCK     = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_FAULT    = 2'd1,
      ERR_BUSY     = 2'd2,
      ERR_DRIVERS  = 2'd3
   } error_type;

   typedef enum logic [2:0] {
      REG_TIMEOUT = 3'd0,
      REG_FAST    = 3'd1,
      REG_SLOW    = 3'd2,
      REG_TRAVEL  = 3'd3,
      REG_BACKOFF = 3'd4,
      REG_HOME    = 3'd5,
      REG_DIR     = 3'd6,
      REG_ORDER   = 3'd7
   } reg_index_type;

   typedef struct packed {
      kind_type      kind;
      logic [1:0]    joint;
      logic [31:0]   value;
      event_type     ev;
      mode_type      mode;
      logic          homed;
      error_type     err;
      logic          last;
   } result_type;

   function automatic logic [15:0] field16(input logic [47:0] r, input logic [1:0] k);
      logic [15:0] f;
      case (k)
         2'd0:    f = r[15:0];
         2'd1:    f = r[31:16];
         2'd2:    f = r[47:32];
         default: f = 16'd0;
      endcase
      return f;
   endfunction

   function automatic logic [19:0] field20(input logic [59:0] r, input logic [1:0] k);
      logic [19:0] f;
      case (k)
         2'd0:    f = r[19:0];
         2'd1:    f = r[39:20];
         2'd2:    f = r[59:40];
         default: f = 20'd0;
      endcase
      return f;
   endfunction

   function automatic result_type cmd(input kind_type k, input logic [1:0] j,
                                      input logic [31:0] v, input event_type e);
      result_type r;
      r.kind  = k;
      r.joint = j;
      r.value = v;
      r.ev    = e;
      r.mode  = MODE_IDLE;
      r.homed = 1'b0;
      r.err   = ERR_OK;
      r.last  = 1'b0;
      return r;
   endfunction

endpackage

>>> rtl/limit_switch_homing_sequencer.sv
// ----------------------------------------------------------------------------
// Limit switch homing sequencer
// Homes the joints one after another and issues stepper commands per request.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser operation, tdata switch/pos/drv
//  rsp     | out | rsp_tvalid/tready  | tuser kind, tdata fields, tlast last
//  csr     | in  | csr_we             | csr_index, csr_wdata
//
//  A request is decoded combinationally into a burst of 1 to 5 results that is
//  loaded into a shift buffer on accept; results leave one per cycle while
//  rsp_tready is high (a plain status is a single result).
//  The next request is taken in the cycle the last result of the burst goes.
//  rsp_tready low holds the buffer; reset is synchronous and clears control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module limit_switch_homing_sequencer
   import lshs_pkg::*;
#(
   parameter int JOINT_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // operation
   input  logic [39:0] req_tdata,   // switch_active, position[32:1], drivers_enabled
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // kind
   output logic [47:0] rsp_tdata,   // joint, value, event_res, mode, homed, error
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_wdata
);

   localparam logic [2:0] JC = 3'(JOINT_COUNT);

   logic [19:0] timeout_ff;
   logic [47:0] fast_ff, slow_ff, backoff_ff;
   logic [59:0] travel_ff, home_ff;
   logic [2:0]  dir_ff;
   logic [5:0]  order_ff;

   mode_type    mode_ff, mode_in;
   logic        homed_ff, homed_in;
   logic [1:0]  slot_ff, slot_in;
   phase_type   phase_ff, phase_in;
   logic        started_ff, started_in;
   logic [31:0] goal_ff, goal_in;
   logic [19:0] ticks_ff, ticks_in;

   result_type  buf_ff [RES_SLOTS];
   result_type  list_in [RES_SLOTS];
   logic [2:0]  cnt_ff, cnt_in;

   logic        req_fire, rsp_fire;
   op_type      op;
   logic        active, drivers;
   logic [31:0] pos;

   assign op      = op_type'(req_tuser);
   assign active  = req_tdata[0];
   assign pos     = req_tdata[32:1];
   assign drivers = req_tdata[33];

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign req_tready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 20'd10000;
         fast_ff    <= '0;
         slow_ff    <= '0;
         travel_ff  <= '0;
         backoff_ff <= '0;
         home_ff    <= '0;
         dir_ff     <= '0;
         order_ff   <= 6'd36;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_TIMEOUT: timeout_ff <= csr_wdata[19:0];
            REG_FAST:    fast_ff    <= csr_wdata[47:0];
            REG_SLOW:    slow_ff    <= csr_wdata[47:0];
            REG_TRAVEL:  travel_ff  <= csr_wdata;
            REG_BACKOFF: backoff_ff <= csr_wdata[47:0];
            REG_HOME:    home_ff    <= csr_wdata;
            REG_DIR:     dir_ff     <= csr_wdata[2:0];
            REG_ORDER:   order_ff   <= csr_wdata[5:0];
            default:     ;
         endcase
      end
   end

   // next state and result burst
   always_comb begin
      logic [2:0]  n;
      logic [1:0]  j;
      logic        pos_dir;
      logic        fast;
      logic [19:0] ticks_inc;
      logic [31:0] goal;
      logic [19:0] hp;
      error_type   err;
      result_type  st;

      mode_in    = mode_ff;
      homed_in   = homed_ff;
      slot_in    = slot_ff;
      phase_in   = phase_ff;
      started_in = started_ff;
      goal_in    = goal_ff;
      ticks_in   = ticks_ff;
      err        = ERR_OK;
      n          = 3'd0;
      for (int i = 0; i < RES_SLOTS; i++) list_in[i] = cmd(KIND_STATUS, 2'd0, 32'd0, EV_NONE);

      case (slot_ff)
         2'd0:    j = order_ff[1:0];
         2'd1:    j = order_ff[3:2];
         2'd2:    j = order_ff[5:4];
         default: j = 2'd0;
      endcase
      pos_dir   = (j != 2'd3) && dir_ff[j];
      fast      = (phase_ff == PH_SEEK_FAST);
      ticks_inc = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + 20'd1;
      goal      = goal_ff;
      hp        = field20(home_ff, j);

      case (op)
         OP_TICK: begin
            if (mode_ff == MODE_HOMING) begin
               ticks_in = ticks_inc;
               if (ticks_inc > timeout_ff) begin
                  list_in[n] = cmd(KIND_HALT, 2'd0, 32'd0, EV_NONE);
                  n = n + 3'd1;
                  list_in[n] = cmd(KIND_EVENT, j, 32'd0, EV_TIMEOUT);
                  n = n + 3'd1;
                  mode_in  = MODE_FAULT;
                  homed_in = 1'b0;
               end else if (phase_ff == PH_SEEK_FAST || phase_ff == PH_SEEK_SLOW) begin
                  if (!started_ff) begin
                     list_in[n] = cmd(KIND_RATE, j,
                        {16'd0, field16(fast ? fast_ff : slow_ff, j)}, EV_NONE);
                     n = n + 3'd1;
                     list_in[n] = cmd(KIND_TARGET, j, pos_dir ?
                        pos + {12'd0, field20(travel_ff, j)} :
                        pos - {12'd0, field20(travel_ff, j)}, EV_NONE);
                     n = n + 3'd1;
                     started_in = 1'b1;
                     if (fast) begin
                        list_in[n] = cmd(KIND_EVENT, j, 32'd0, EV_STARTED);
                        n = n + 3'd1;
                     end
                  end
                  if (active) begin
                     list_in[n] = cmd(KIND_TARGET, j, pos, EV_NONE);
                     n = n + 3'd1;
                     started_in = 1'b0;
                     if (fast) begin
                        phase_in = PH_BACKOFF;
                     end else begin
                        list_in[n] = cmd(KIND_SETPOS, j, {{12{hp[19]}}, hp}, EV_NONE);
                        n = n + 3'd1;
                        phase_in = PH_RELEASE;
                     end
                  end
               end else begin
                  if (!started_ff) begin
                     goal = pos_dir ? pos - {16'd0, field16(backoff_ff, j)} :
                                      pos + {16'd0, field16(backoff_ff, j)};
                     goal_in = goal;
                     list_in[n] = cmd(KIND_RATE, j, {16'd0, field16(fast_ff, j)}, EV_NONE);
                     n = n + 3'd1;
                     list_in[n] = cmd(KIND_TARGET, j, goal, EV_NONE);
                     n = n + 3'd1;
                     started_in = 1'b1;
                  end
                  if (pos == goal) begin
                     if (active) begin
                        list_in[n] = cmd(KIND_HALT, 2'd0, 32'd0, EV_NONE);
                        n = n + 3'd1;
                        list_in[n] = cmd(KIND_EVENT, j, 32'd0, EV_STUCK);
                        n = n + 3'd1;
                        mode_in  = MODE_FAULT;
                        homed_in = 1'b0;
                     end else if (phase_ff == PH_BACKOFF) begin
                        phase_in   = PH_SEEK_SLOW;
                        started_in = 1'b0;
                     end else if (({1'b0, slot_ff} + 3'd1) < JC) begin
                        slot_in    = slot_ff + 2'd1;
                        ticks_in   = 20'd0;
                        phase_in   = PH_SEEK_FAST;
                        started_in = 1'b0;
                     end else begin
                        homed_in = 1'b1;
                        mode_in  = MODE_IDLE;
                        list_in[n] = cmd(KIND_EVENT, 2'd0, 32'd0, EV_ALL_HOMED);
                        n = n + 3'd1;
                     end
                  end
               end
            end
         end
         OP_START: begin
            if (mode_ff == MODE_FAULT) begin
               err = ERR_FAULT;
            end else if (mode_ff != MODE_IDLE) begin
               err = ERR_BUSY;
            end else if (!drivers) begin
               err = ERR_DRIVERS;
            end else begin
               homed_in   = 1'b0;
               slot_in    = 2'd0;
               phase_in   = PH_SEEK_FAST;
               started_in = 1'b0;
               ticks_in   = 20'd0;
               mode_in    = MODE_HOMING;
            end
         end
         OP_STOP: begin
            list_in[n] = cmd(KIND_HALT, 2'd0, 32'd0, EV_NONE);
            n = n + 3'd1;
            mode_in = MODE_IDLE;
         end
         default: begin
            list_in[n] = cmd(KIND_HALT, 2'd0, 32'd0, EV_NONE);
            n = n + 3'd1;
            if (mode_ff != MODE_FAULT) mode_in = MODE_IDLE;
            homed_in = 1'b0;
         end
      endcase

      st       = cmd(KIND_STATUS, 2'd0, 32'd0, EV_NONE);
      st.mode  = mode_in;
      st.homed = homed_in;
      st.err   = err;
      st.last  = 1'b1;
      list_in[n] = st;
      cnt_in = n + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         homed_ff   <= 1'b0;
         slot_ff    <= 2'd0;
         phase_ff   <= PH_SEEK_FAST;
         started_ff <= 1'b0;
         goal_ff    <= 32'd0;
         ticks_ff   <= 20'd0;
      end else if (req_fire) begin
         mode_ff    <= mode_in;
         homed_ff   <= homed_in;
         slot_ff    <= slot_in;
         phase_ff   <= phase_in;
         started_ff <= started_in;
         goal_ff    <= goal_in;
         ticks_ff   <= ticks_in;
      end
   end

   // load a burst on accept, advance one entry per delivered result
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (req_fire) begin
         cnt_ff <= cnt_in;
      end else if (rsp_fire) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_ff <= list_in;
      end else if (rsp_fire) begin
         for (int i = 0; i < RES_SLOTS - 1; i++) buf_ff[i] <= buf_ff[i + 1];
      end
   end

   assign rsp_tuser = buf_ff[0].kind;
   assign rsp_tlast = buf_ff[0].last;
   assign rsp_tdata = {6'd0, buf_ff[0].err, buf_ff[0].homed, buf_ff[0].mode,
                       buf_ff[0].ev, buf_ff[0].value, buf_ff[0].joint};

   `ASSERT_IMPLIES(a_last_ends_burst, clock, reset, rsp_tvalid && rsp_tlast, cnt_ff == 3'd1)
   `ASSERT_NEXT(a_accept_gives_result, clock, reset, req_fire, rsp_tvalid)
   `ASSERT_IMPLIES(a_homed_not_homing, clock, reset, homed_ff, mode_ff != MODE_HOMING)

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Homing sequencer testbench
// Drives requests on the req stream and checks every result on the rsp
// stream against an in-bench prediction of the sequencer. Covers command
// guards, register extremes, full homing runs with random settings,
// timeout and stuck-switch faults, and mixed random traffic under
// random back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb;
   import lshs_pkg::*;

   localparam int JOINTS = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [59:0] csr_wdata = '0;

   limit_switch_homing_sequencer #(
      .JOINT_COUNT(JOINTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #2 clock = ~clock;

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // predicted register file
   logic [19:0] cfg_timeout;
   logic [47:0] cfg_fast;
   logic [47:0] cfg_slow;
   logic [59:0] cfg_travel;
   logic [47:0] cfg_backoff;
   logic [59:0] cfg_home;
   logic [2:0]  cfg_dir;
   logic [5:0]  cfg_order;

   // predicted sequencer state
   mode_type    m_mode;
   logic        m_homed;
   logic [1:0]  m_slot;
   phase_type   m_phase;
   logic        m_started;
   logic [31:0] m_goal;
   logic [19:0] m_ticks;

   result_type  pending_results[$];
   result_type  seen_result;
   result_type  want_result;
   int          mismatches = 0;
   int          requests_sent = 0;
   int          idle_pct = 0;
   int          stall_left = 0;
   logic        calm = 1'b0;

   function automatic logic [15:0] rate_of(input logic [47:0] regs, input logic [1:0] j);
      logic [47:0] s;
      if (j == 2'd3) return 16'd0;
      s = regs >> (16 * j);
      return s[15:0];
   endfunction

   function automatic logic [19:0] span_of(input logic [59:0] regs, input logic [1:0] j);
      logic [59:0] s;
      if (j == 2'd3) return 20'd0;
      s = regs >> (20 * j);
      return s[19:0];
   endfunction

   function automatic void push_result(input kind_type k, input logic [1:0] j,
                                       input logic [31:0] v, input event_type e);
      result_type r;
      r.kind  = k;
      r.joint = j;
      r.value = v;
      r.ev    = e;
      r.mode  = MODE_IDLE;
      r.homed = 1'b0;
      r.err   = ERR_OK;
      r.last  = 1'b0;
      pending_results.push_back(r);
   endfunction

   function automatic void enter_phase(input phase_type p);
      m_phase   = p;
      m_started = 1'b0;
   endfunction

   function automatic void enter_fault(input logic [1:0] j, input event_type e);
      push_result(KIND_HALT, 2'd0, 32'd0, EV_NONE);
      push_result(KIND_EVENT, j, 32'd0, e);
      m_mode  = MODE_FAULT;
      m_homed = 1'b0;
   endfunction

   function automatic void reset_model();
      cfg_timeout = 20'd10000;
      cfg_fast    = '0;
      cfg_slow    = '0;
      cfg_travel  = '0;
      cfg_backoff = '0;
      cfg_home    = '0;
      cfg_dir     = '0;
      cfg_order   = 6'd36;
      m_mode      = MODE_IDLE;
      m_homed     = 1'b0;
      m_slot      = 2'd0;
      m_phase     = PH_SEEK_FAST;
      m_started   = 1'b0;
      m_goal      = '0;
      m_ticks     = '0;
   endfunction

   function automatic void apply_register(input reg_index_type idx, input logic [59:0] v);
      case (idx)
         REG_TIMEOUT: cfg_timeout = v[19:0];
         REG_FAST:    cfg_fast    = v[47:0];
         REG_SLOW:    cfg_slow    = v[47:0];
         REG_TRAVEL:  cfg_travel  = v;
         REG_BACKOFF: cfg_backoff = v[47:0];
         REG_HOME:    cfg_home    = v;
         REG_DIR:     cfg_dir     = v[2:0];
         default:     cfg_order   = v[5:0];
      endcase
   endfunction

   function automatic void advance_homing(input logic sw, input logic [31:0] pos);
      logic [5:0]  order_bits;
      logic [1:0]  j;
      logic        up;
      logic        fast;
      logic [31:0] span;
      logic [31:0] back;
      logic [19:0] hp;
      order_bits = cfg_order >> (2 * m_slot);
      j  = (m_slot == 2'd3) ? 2'd0 : order_bits[1:0];
      up = (j != 2'd3) && cfg_dir[j];
      if (m_ticks != TICK_MAX) m_ticks = m_ticks + 20'd1;
      if (m_ticks > cfg_timeout) begin
         enter_fault(j, EV_TIMEOUT);
         return;
      end
      if (m_phase == PH_SEEK_FAST || m_phase == PH_SEEK_SLOW) begin
         fast = (m_phase == PH_SEEK_FAST);
         if (!m_started) begin
            span = {12'd0, span_of(cfg_travel, j)};
            push_result(KIND_RATE, j, {16'd0, rate_of(fast ? cfg_fast : cfg_slow, j)}, EV_NONE);
            push_result(KIND_TARGET, j, up ? pos + span : pos - span, EV_NONE);
            m_started = 1'b1;
            if (fast) push_result(KIND_EVENT, j, 32'd0, EV_STARTED);
         end
         if (!sw) return;
         push_result(KIND_TARGET, j, pos, EV_NONE);
         if (fast) begin
            enter_phase(PH_BACKOFF);
         end else begin
            hp = span_of(cfg_home, j);
            push_result(KIND_SETPOS, j, {{12{hp[19]}}, hp}, EV_NONE);
            enter_phase(PH_RELEASE);
         end
         return;
      end
      if (!m_started) begin
         back   = {16'd0, rate_of(cfg_backoff, j)};
         m_goal = up ? pos - back : pos + back;
         push_result(KIND_RATE, j, {16'd0, rate_of(cfg_fast, j)}, EV_NONE);
         push_result(KIND_TARGET, j, m_goal, EV_NONE);
         m_started = 1'b1;
      end
      if (pos != m_goal) return;
      if (sw) begin
         enter_fault(j, EV_STUCK);
         return;
      end
      if (m_phase == PH_BACKOFF) begin
         enter_phase(PH_SEEK_SLOW);
         return;
      end
      if (m_slot + 1 < JOINTS) begin
         m_slot  = m_slot + 2'd1;
         m_ticks = '0;
         enter_phase(PH_SEEK_FAST);
         return;
      end
      m_homed = 1'b1;
      m_mode  = MODE_IDLE;
      push_result(KIND_EVENT, 2'd0, 32'd0, EV_ALL_HOMED);
   endfunction

   function automatic void predict_request(input op_type op, input logic sw,
                                           input logic [31:0] pos, input logic drv);
      result_type r;
      error_type  err;
      err = ERR_OK;
      case (op)
         OP_TICK: begin
            if (m_mode == MODE_HOMING) advance_homing(sw, pos);
         end
         OP_START: begin
            if (m_mode == MODE_FAULT) err = ERR_FAULT;
            else if (m_mode != MODE_IDLE) err = ERR_BUSY;
            else if (!drv) err = ERR_DRIVERS;
            else begin
               m_homed = 1'b0;
               m_slot  = 2'd0;
               enter_phase(PH_SEEK_FAST);
               m_ticks = '0;
               m_mode  = MODE_HOMING;
            end
         end
         OP_STOP: begin
            push_result(KIND_HALT, 2'd0, 32'd0, EV_NONE);
            m_mode = MODE_IDLE;
         end
         default: begin
            push_result(KIND_HALT, 2'd0, 32'd0, EV_NONE);
            if (m_mode != MODE_FAULT) m_mode = MODE_IDLE;
            m_homed = 1'b0;
         end
      endcase
      r.kind  = KIND_STATUS;
      r.joint = 2'd0;
      r.value = 32'd0;
      r.ev    = EV_NONE;
      r.mode  = m_mode;
      r.homed = m_homed;
      r.err   = err;
      r.last  = 1'b1;
      pending_results.push_back(r);
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("kind=%0d joint=%0d value=%h ev=%0d mode=%0d homed=%0b err=%0d last=%0b",
                       r.kind, r.joint, r.value, r.ev, r.mode, r.homed, r.err, r.last);
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // response back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result.kind  = kind_type'(rsp_tuser);
         seen_result.joint = rsp_tdata[1:0];
         seen_result.value = rsp_tdata[33:2];
         seen_result.ev    = event_type'(rsp_tdata[36:34]);
         seen_result.mode  = mode_type'(rsp_tdata[38:37]);
         seen_result.homed = rsp_tdata[39];
         seen_result.err   = error_type'(rsp_tdata[41:40]);
         seen_result.last  = rsp_tlast;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %s", $time,
                     describe(seen_result));
            mismatches++;
         end else begin
            want_result = pending_results.pop_front();
            if (seen_result !== want_result || rsp_tdata[47:42] !== 6'd0) begin
               $display("%0t: result mismatch, expected %s", $time, describe(want_result));
               $display("%0t:                  actual   %s tdata=%h", $time,
                        describe(seen_result), rsp_tdata);
               mismatches++;
            end
         end
      end
   end

   task automatic send_request(input op_type op, input logic sw, input logic [31:0] pos,
                               input logic drv);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, drv, pos, sw};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      predict_request(op, sw, pos, drv);
      requests_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [59:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      apply_register(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic randomize_config();
      logic [47:0] back;
      int          k;
      if ($urandom_range(0, 4) == 0) csr_write(REG_TIMEOUT, {40'd0, TICK_MAX});
      else csr_write(REG_TIMEOUT, 60'($urandom_range(100, 5000)));
      csr_write(REG_FAST, 60'({$urandom, $urandom}));
      csr_write(REG_SLOW, 60'({$urandom, $urandom}));
      csr_write(REG_TRAVEL, 60'({$urandom, $urandom}));
      back = '0;
      for (k = 0; k < 3; k++) begin
         back = back >> 16;
         if ($urandom_range(0, 3) != 0) back[47:32] = 16'($urandom_range(1, 65535));
      end
      csr_write(REG_BACKOFF, {12'd0, back});
      csr_write(REG_HOME, 60'({$urandom, $urandom}));
      csr_write(REG_DIR, 60'($urandom_range(0, 7)));
      csr_write(REG_ORDER, 60'($urandom_range(0, 63)));
   endtask

   // bias tick inputs toward well-formed trips and backoff arrivals
   task automatic choose_tick_inputs(output logic sw, output logic [31:0] pos);
      pos = rand_pos();
      if (m_phase == PH_SEEK_FAST || m_phase == PH_SEEK_SLOW) begin
         sw = ($urandom_range(0, 99) < 35);
      end else if (m_started && $urandom_range(0, 99) < 50) begin
         pos = m_goal;
         sw  = ($urandom_range(0, 99) < 8);
      end else begin
         sw = ($urandom_range(0, 99) < 15);
      end
   endtask

   task automatic home_sequence(input int max_ticks, input int noise_pct);
      int          n;
      logic        sw;
      logic [31:0] pos;
      if (m_mode != MODE_IDLE) send_request(OP_STOP, 1'($urandom_range(0, 1)), rand_pos(), 1'b1);
      send_request(OP_START, 1'($urandom_range(0, 1)), rand_pos(), 1'b1);
      for (n = 0; n < max_ticks && m_mode == MODE_HOMING; n++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_request(op_type'($urandom_range(1, 3)), 1'($urandom_range(0, 1)), rand_pos(),
                         1'($urandom_range(0, 1)));
         end else begin
            choose_tick_inputs(sw, pos);
            send_request(OP_TICK, sw, pos, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_command_checks();
      idle_pct = 25;
      send_request(OP_TICK, 1'b0, 32'h0000_0000, 1'b0);
      send_request(OP_START, 1'b1, 32'hFFFF_FFFF, 1'b0);
      send_request(OP_DISABLE, 1'b0, 32'h0000_0000, 1'b1);
      send_request(OP_STOP, 1'b1, 32'h7FFF_FFFF, 1'b0);
      send_request(OP_START, 1'b0, 32'h0000_0000, 1'b1);
      send_request(OP_START, 1'b0, 32'h0000_0000, 1'b1);
      // fast trip on the first tick
      send_request(OP_TICK, 1'b1, 32'h7FFF_FFFF, 1'b1);
      // zero backoff: goal equals position at once
      send_request(OP_TICK, 1'b0, 32'h8000_0000, 1'b0);
      send_request(OP_TICK, 1'b0, 32'h1234_5678, 1'b1);
      send_request(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1);
      // switch still on at release
      send_request(OP_TICK, 1'b1, 32'h0000_0000, 1'b1);
      send_request(OP_START, 1'b0, 32'h0000_0000, 1'b1);
      send_request(OP_TICK, 1'b1, 32'h5555_5555, 1'b1);
      send_request(OP_DISABLE, 1'b1, 32'hAAAA_AAAA, 1'b1);
      send_request(OP_STOP, 1'b0, 32'h0000_0000, 1'b0);
      send_request(OP_START, 1'b0, 32'h0000_0000, 1'b1);
      send_request(OP_TICK, 1'b0, 32'h0000_0001, 1'b1);
      send_request(OP_DISABLE, 1'b0, 32'h0000_0000, 1'b0);
      send_request(OP_START, 1'b0, 32'h0000_0000, 1'b1);
      send_request(OP_STOP, 1'b0, 32'h0000_0000, 1'b1);
   endtask

   task automatic test_register_extremes();
      int i;
      idle_pct = 40;
      drain_results();
      for (i = 0; i < 8; i++) csr_write(reg_index_type'(i), '1);
      csr_write(REG_ORDER, 60'd36);
      home_sequence(40, 0);
      drain_results();
      // every slot names the joint with no packed fields
      csr_write(REG_ORDER, '1);
      home_sequence(30, 0);
      drain_results();
      for (i = 0; i < 8; i++) csr_write(reg_index_type'(i), '0);
      home_sequence(3, 0);
      send_request(OP_TICK, 1'b1, 32'h0000_0000, 1'b1);
   endtask

   task automatic test_random_homing();
      int round;
      round = 0;
      while (requests_sent < 280) begin
         drain_results();
         randomize_config();
         idle_pct = 30 * (round % 3);
         home_sequence(80, 3);
         round++;
      end
   endtask

   task automatic test_timeout_faults();
      int i;
      idle_pct = 30;
      for (i = 0; i < 5; i++) begin
         drain_results();
         randomize_config();
         csr_write(REG_TIMEOUT, 60'($urandom_range(0, 6)));
         home_sequence(25, 0);
         send_request(OP_TICK, 1'($urandom_range(0, 1)), rand_pos(), 1'b1);
      end
   endtask

   task automatic test_mixed_requests(input int count);
      int          i;
      int          r;
      op_type      op;
      logic        sw;
      logic [31:0] pos;
      idle_pct = 50;
      drain_results();
      randomize_config();
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60) op = OP_TICK;
         else if (r < 78) op = OP_START;
         else if (r < 89) op = OP_STOP;
         else op = OP_DISABLE;
         choose_tick_inputs(sw, pos);
         if ($urandom_range(0, 3) == 0) sw = 1'($urandom_range(0, 1));
         send_request(op, sw, pos, $urandom_range(0, 99) < 80);
      end
   endtask

   task automatic test_unstalled_homing();
      calm = 1'b1;
      drain_results();
      randomize_config();
      home_sequence(60, 0);
      home_sequence(40, 5);
   endtask

   initial begin
      reset_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_command_checks();
      test_register_extremes();
      test_random_homing();
      test_timeout_faults();
      test_mixed_requests(80);
      test_unstalled_homing();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> limit_switch_homing_sequencer.f
+incdir+rtl
rtl/lshs_pkg.sv
rtl/limit_switch_homing_sequencer.sv
tb/tb.sv
